// ===== rtl/core/lzhuf_pkg.sv =====
package lzhuf_pkg;

    typedef logic [9:0]  t_node;
    typedef logic [15:0] t_freq;
    typedef logic [11:0] t_wpos;

    // Tree geometry: 314 symbols, 627 nodes, root at 626.
    localparam t_node NUM_SYM    = 10'd314;
    localparam t_node TBL        = 10'd627;
    localparam t_node ROOT       = 10'd626;
    localparam t_node PAR_DEPTH  = 10'd941;
    localparam t_node INIT_TOP_CH = 10'd624;
    localparam logic [8:0] LAST_SYM   = 9'd313;
    localparam logic [8:0] LIT_LIMIT  = 9'd256;
    localparam logic [8:0] MATCH_BIAS = 9'd253;

    localparam t_freq FREQ_LIMIT = 16'h8000;
    localparam t_freq FREQ_SENT  = 16'hFFFF;

    localparam t_wpos WIN_START = 12'd4036;
    localparam t_wpos WIN_LAST  = 12'd4095;
    localparam logic [7:0] FILL_BYTE = 8'h20;

    localparam logic [1:0] PH_SYMBOL  = 2'd0;
    localparam logic [1:0] PH_PREFIX  = 2'd1;
    localparam logic [1:0] PH_EXTRA   = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    typedef struct packed {
        logic [7:0] start;
        logic [5:0] base;
        logic [3:0] len;
    } t_grp;

    // Position prefix group: first prefix code, first upper code, code length.
    function automatic t_grp grp_of(input logic [7:0] pfx);
        t_grp g;
        priority if (pfx >= 8'hF0) g = '{8'hF0, 6'd48, 4'd8};
        else if (pfx >= 8'hC0)     g = '{8'hC0, 6'd24, 4'd7};
        else if (pfx >= 8'h90)     g = '{8'h90, 6'd12, 4'd6};
        else if (pfx >= 8'h50)     g = '{8'h50, 6'd4,  4'd5};
        else if (pfx >= 8'h20)     g = '{8'h20, 6'd1,  4'd4};
        else                       g = '{8'h00, 6'd0,  4'd3};
        return g;
    endfunction

endpackage

// ===== rtl/core/lzhuf_stream_decoder_core.sv =====
// LZHUF decoder core: adaptive Huffman symbols plus LZSS window copies.
// Input channel (s_axis): one compressed bit per transaction, MSB first;
// tuser[0] = start, which reinitializes tree, window and counters first.
// Output channel (m_axis): one decoded byte per transaction; tlast marks the
// last byte caused by one input bit; tuser carries done/overrun status.
// Config channel (i_cfg_*): expected output length, always ready.
// After reset, and for every start transaction, an init pass (tree build,
// then one window byte per cycle) runs with s_axis held off. A leaf bit runs
// the frequency update up the tree, swapping nodes where the order requires
// it. When the root count hits 0x8000 a rebuild with an insertion sort runs
// first. Match copies read each byte through the single-port window read
// before emitting it. One result waits in the output register; the core
// stalls only when it needs to emit while that register is still full.
module lzhuf_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] in_bit, [7:1] zero
    input  logic [0:0]  s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] produced_count
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // [0] stream_done, [1] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import lzhuf_pkg::*;

    localparam logic [5:0] ST_INIT_LEAF = 6'd0;
    localparam logic [5:0] ST_INIT_N0   = 6'd1;
    localparam logic [5:0] ST_INIT_N1   = 6'd2;
    localparam logic [5:0] ST_INIT_N2   = 6'd3;
    localparam logic [5:0] ST_INIT_N3   = 6'd4;
    localparam logic [5:0] ST_INIT_TOP  = 6'd5;
    localparam logic [5:0] ST_INIT_WIN  = 6'd6;
    localparam logic [5:0] ST_IDLE      = 6'd7;
    localparam logic [5:0] ST_PROC      = 6'd8;
    localparam logic [5:0] ST_SYM_EV    = 6'd9;
    localparam logic [5:0] ST_UP_CHK    = 6'd10;
    localparam logic [5:0] ST_PAR       = 6'd11;
    localparam logic [5:0] ST_PAR2      = 6'd12;
    localparam logic [5:0] ST_UP_A      = 6'd13;
    localparam logic [5:0] ST_UP_B      = 6'd14;
    localparam logic [5:0] ST_UP_C      = 6'd15;
    localparam logic [5:0] ST_UP_S      = 6'd16;
    localparam logic [5:0] ST_SW1       = 6'd17;
    localparam logic [5:0] ST_SW2       = 6'd18;
    localparam logic [5:0] ST_SW3       = 6'd19;
    localparam logic [5:0] ST_SW4       = 6'd20;
    localparam logic [5:0] ST_SW5       = 6'd21;
    localparam logic [5:0] ST_SW6       = 6'd22;
    localparam logic [5:0] ST_ROOT      = 6'd23;
    localparam logic [5:0] ST_ROOT2     = 6'd24;
    localparam logic [5:0] ST_EMIT      = 6'd25;
    localparam logic [5:0] ST_CP_RD     = 6'd26;
    localparam logic [5:0] ST_RB_A      = 6'd27;
    localparam logic [5:0] ST_RB_B      = 6'd28;
    localparam logic [5:0] ST_RB_C      = 6'd29;
    localparam logic [5:0] ST_RB_D      = 6'd30;
    localparam logic [5:0] ST_RB_E      = 6'd31;
    localparam logic [5:0] ST_RB_F      = 6'd32;
    localparam logic [5:0] ST_RB_G      = 6'd33;
    localparam logic [5:0] ST_RB_H      = 6'd34;
    localparam logic [5:0] ST_RB_I      = 6'd35;
    localparam logic [5:0] ST_RB_J      = 6'd36;

    // memories
    t_freq      r_freq_mem   [0:627];
    t_node      r_child_mem  [0:626];
    t_node      r_parent_mem [0:940];
    logic [7:0] r_win_mem    [0:4095];

    t_freq      r_freq_rd;
    t_node      r_child_rd;
    t_node      r_parent_rd;
    logic [7:0] r_win_rd;

    logic       w_freq_we,   w_child_we,   w_parent_we,   w_win_we;
    t_node      w_freq_wa,   w_child_wa,   w_parent_wa;
    t_wpos      w_win_wa;
    t_freq      w_freq_wd;
    t_node      w_child_wd,  w_parent_wd;
    logic [7:0] w_win_wd;
    t_node      w_freq_ra,   w_child_ra,   w_parent_ra;
    t_wpos      w_win_ra;

    // control and datapath registers
    logic [5:0]  r_state, n_state;
    logic [11:0] r_idx,   n_idx;
    t_node       r_j,     n_j;
    t_node       r_m,     n_m;
    t_node       r_c,     n_c;
    t_node       r_l,     n_l;
    t_freq       r_k,     n_k;
    t_freq       r_fl,    n_fl;
    t_node       r_a,     n_a;
    t_node       r_b,     n_b;
    logic [8:0]  r_sym,   n_sym;
    logic        r_bit,   n_bit;
    logic        r_pend,  n_pend;
    logic        r_first, n_first;
    logic        r_lit,   n_lit;
    t_node       r_node,  n_node;
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_ebl,   n_ebl;
    logic [11:0] r_acc,   n_acc;
    logic [5:0]  r_mlen,  n_mlen;
    logic [31:0] r_total, n_total;
    t_wpos       r_wp,    n_wp;
    t_wpos       r_from,  n_from;
    logic [5:0]  r_cnt,   n_cnt;
    logic [31:0] r_olen;

    logic        r_ov,    n_ov;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;
    logic        r_odone, n_odone;
    logic        r_ostat, n_ostat;
    logic [31:0] r_ocnt,  n_ocnt;

    // helpers
    logic [7:0]  w_acc8;
    t_grp        w_grp;
    logic [5:0]  w_up6;
    logic [11:0] w_acc_x;
    logic [3:0]  w_ebl_dec;
    logic [31:0] w_total_inc;
    logic        w_out_free;
    logic [7:0]  w_emit_byte;
    t_freq       w_half;
    t_node       w_sym_c;
    t_node       w_leaf;
    t_node       w_sym_node;

    assign w_acc8      = {r_acc[6:0], r_bit};
    assign w_grp       = grp_of(w_acc8);
    assign w_up6       = w_grp.base + 6'((w_acc8 - w_grp.start) >> (4'd8 - w_grp.len));
    assign w_acc_x     = {r_acc[11:6], r_acc[4:0], r_bit};
    assign w_ebl_dec   = r_ebl - 4'd1;
    assign w_total_inc = r_total + 32'd1;
    assign w_out_free  = ~r_ov | m_axis_tready;
    assign w_emit_byte = r_lit ? r_sym[7:0] : r_win_rd;
    assign w_half      = 16'((17'(r_freq_rd) + 17'd1) >> 1);
    assign w_sym_c     = (r_a < TBL) ? r_child_rd : '0;
    assign w_leaf      = w_sym_c - TBL;
    assign w_sym_node  = t_node'({1'b0, r_sym}) + TBL;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_ocnt, r_obyte};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_ostat, r_odone};

    always_comb begin
        n_state = r_state;  n_idx = r_idx;    n_j = r_j;      n_m = r_m;
        n_c = r_c;          n_l = r_l;        n_k = r_k;      n_fl = r_fl;
        n_a = r_a;          n_b = r_b;        n_sym = r_sym;  n_bit = r_bit;
        n_pend = r_pend;    n_first = r_first; n_lit = r_lit; n_node = r_node;
        n_phase = r_phase;  n_ebl = r_ebl;    n_acc = r_acc;  n_mlen = r_mlen;
        n_total = r_total;  n_wp = r_wp;      n_from = r_from; n_cnt = r_cnt;
        n_ov = r_ov & ~m_axis_tready;
        n_obyte = r_obyte;  n_olast = r_olast; n_odone = r_odone;
        n_ostat = r_ostat;  n_ocnt = r_ocnt;

        w_freq_we = 1'b0;   w_freq_wa = '0;   w_freq_wd = '0;   w_freq_ra = '0;
        w_child_we = 1'b0;  w_child_wa = '0;  w_child_wd = '0;  w_child_ra = '0;
        w_parent_we = 1'b0; w_parent_wa = '0; w_parent_wd = '0; w_parent_ra = '0;
        w_win_we = 1'b0;    w_win_wa = '0;    w_win_wd = '0;
        w_win_ra = r_from + t_wpos'(r_cnt);

        unique case (r_state)
            ST_INIT_LEAF: begin
                w_freq_we = 1'b1;   w_freq_wa = r_idx[9:0];   w_freq_wd = 16'd1;
                w_child_we = 1'b1;  w_child_wa = r_idx[9:0];  w_child_wd = r_idx[9:0] + TBL;
                w_parent_we = 1'b1; w_parent_wa = r_idx[9:0] + TBL; w_parent_wd = r_idx[9:0];
                if (r_idx[9:0] == LAST_SYM[9:0] + 10'd0 && r_idx[8:0] == LAST_SYM) begin
                    n_idx = '0;
                    n_j = NUM_SYM;
                    n_state = ST_INIT_N0;
                end else begin
                    n_idx = r_idx + 12'd1;
                end
            end
            ST_INIT_N0: begin
                w_freq_ra = r_idx[9:0];
                n_state = ST_INIT_N1;
            end
            ST_INIT_N1: begin
                n_k = r_freq_rd;
                w_freq_ra = r_idx[9:0] + 10'd1;
                n_state = ST_INIT_N2;
            end
            ST_INIT_N2: begin
                w_freq_we = 1'b1;   w_freq_wa = r_j;    w_freq_wd = r_k + r_freq_rd;
                w_child_we = 1'b1;  w_child_wa = r_j;   w_child_wd = r_idx[9:0];
                w_parent_we = 1'b1; w_parent_wa = r_idx[9:0]; w_parent_wd = r_j;
                n_state = ST_INIT_N3;
            end
            ST_INIT_N3: begin
                w_parent_we = 1'b1; w_parent_wa = r_idx[9:0] + 10'd1; w_parent_wd = r_j;
                if (r_j == ROOT) begin
                    n_state = ST_INIT_TOP;
                end else begin
                    n_j = r_j + 10'd1;
                    n_idx = r_idx + 12'd2;
                    n_state = ST_INIT_N0;
                end
            end
            ST_INIT_TOP: begin
                w_freq_we = 1'b1;   w_freq_wa = TBL;    w_freq_wd = FREQ_SENT;
                w_parent_we = 1'b1; w_parent_wa = ROOT; w_parent_wd = '0;
                n_idx = '0;
                n_state = ST_INIT_WIN;
            end
            ST_INIT_WIN: begin
                w_win_we = 1'b1;
                w_win_wa = r_idx;
                w_win_wd = (r_idx < WIN_START) ? FILL_BYTE : 8'h00;
                if (r_idx == WIN_LAST) begin
                    n_node = INIT_TOP_CH;
                    n_phase = PH_SYMBOL;
                    n_ebl = '0;
                    n_acc = '0;
                    n_mlen = '0;
                    n_total = '0;
                    n_wp = WIN_START;
                    n_pend = 1'b0;
                    n_state = r_pend ? ST_PROC : ST_IDLE;
                end else begin
                    n_idx = r_idx + 12'd1;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_bit = s_axis_tdata[0];
                    if (s_axis_tuser[0]) begin
                        n_pend = 1'b1;
                        n_idx = '0;
                        n_state = ST_INIT_LEAF;
                    end else begin
                        n_state = ST_PROC;
                    end
                end
            end
            ST_PROC: begin
                n_state = ST_IDLE;
                if (r_phase != PH_STOPPED && r_total < r_olen) begin
                    unique case (r_phase)
                        PH_SYMBOL: begin
                            n_a = r_node + t_node'(r_bit);
                            w_child_ra = (n_a < TBL) ? n_a : '0;
                            n_state = ST_SYM_EV;
                        end
                        PH_PREFIX: begin
                            n_acc = {4'b0, w_acc8};
                            n_ebl = w_ebl_dec;
                            if (w_ebl_dec == 4'd0) begin
                                n_acc = {w_up6, w_acc8[5:0]};
                                n_ebl = w_grp.len - 4'd2;
                                n_phase = PH_EXTRA;
                            end
                        end
                        PH_EXTRA: begin
                            n_acc = w_acc_x;
                            n_ebl = w_ebl_dec;
                            if (w_ebl_dec == 4'd0) begin
                                n_phase = PH_SYMBOL;
                                n_from = r_wp - w_acc_x - 12'd1;
                                n_cnt = '0;
                                n_lit = 1'b0;
                                n_state = ST_CP_RD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SYM_EV: begin
                if (w_sym_c < TBL) begin
                    n_node = w_sym_c;
                    n_state = ST_IDLE;
                end else begin
                    n_sym = (w_leaf > t_node'(LAST_SYM)) ? LAST_SYM : w_leaf[8:0];
                    w_freq_ra = ROOT;
                    n_state = ST_UP_CHK;
                end
            end
            ST_UP_CHK: begin
                if (r_freq_rd == FREQ_LIMIT) begin
                    n_idx = '0;
                    n_j = '0;
                    n_state = ST_RB_A;
                end else begin
                    n_c = w_sym_node;
                    n_first = 1'b1;
                    n_state = ST_PAR;
                end
            end
            ST_PAR: begin
                w_parent_ra = r_c;
                n_state = ST_PAR2;
            end
            ST_PAR2: begin
                n_c = r_parent_rd;
                n_first = 1'b0;
                if (r_parent_rd >= TBL || (r_parent_rd == '0 && !r_first)) begin
                    n_state = ST_ROOT;
                end else begin
                    n_state = ST_UP_A;
                end
            end
            ST_UP_A: begin
                w_freq_ra = r_c;
                n_state = ST_UP_B;
            end
            ST_UP_B: begin
                n_k = r_freq_rd + 16'd1;
                w_freq_ra = r_c + 10'd1;
                n_state = ST_UP_C;
            end
            ST_UP_C: begin
                if (r_k > r_freq_rd) begin
                    n_l = r_c + 10'd1;
                    n_fl = r_freq_rd;
                    if (r_c + 10'd1 < TBL) begin
                        w_freq_ra = r_c + 10'd2;
                        n_state = ST_UP_S;
                    end else begin
                        n_l = ROOT;
                        n_state = ST_SW1;
                    end
                end else begin
                    w_freq_we = 1'b1; w_freq_wa = r_c; w_freq_wd = r_k;
                    n_state = ST_PAR;
                end
            end
            ST_UP_S: begin
                // scan upward for the last node whose count is below the new one
                if (r_k > r_freq_rd) begin
                    n_l = r_l + 10'd1;
                    n_fl = r_freq_rd;
                    if (r_l + 10'd1 < TBL) begin
                        w_freq_ra = r_l + 10'd2;
                    end else begin
                        n_l = ROOT;
                        n_state = ST_SW1;
                    end
                end else begin
                    n_state = ST_SW1;
                end
            end
            ST_SW1: begin
                w_freq_we = 1'b1; w_freq_wa = r_c; w_freq_wd = r_fl;
                w_child_ra = r_c;
                n_state = ST_SW2;
            end
            ST_SW2: begin
                w_freq_we = 1'b1; w_freq_wa = r_l; w_freq_wd = r_k;
                n_a = r_child_rd;
                w_child_ra = r_l;
                n_state = ST_SW3;
            end
            ST_SW3: begin
                n_b = r_child_rd;
                w_child_we = 1'b1; w_child_wa = r_l; w_child_wd = r_a;
                w_parent_we = (r_a < PAR_DEPTH); w_parent_wa = r_a; w_parent_wd = r_l;
                n_state = ST_SW4;
            end
            ST_SW4: begin
                w_child_we = 1'b1; w_child_wa = r_c; w_child_wd = r_b;
                w_parent_we = (r_a < TBL); w_parent_wa = r_a + 10'd1; w_parent_wd = r_l;
                n_state = ST_SW5;
            end
            ST_SW5: begin
                w_parent_we = (r_b < PAR_DEPTH); w_parent_wa = r_b; w_parent_wd = r_c;
                n_state = ST_SW6;
            end
            ST_SW6: begin
                w_parent_we = (r_b < TBL); w_parent_wa = r_b + 10'd1; w_parent_wd = r_c;
                n_c = r_l;
                n_state = ST_PAR;
            end
            ST_ROOT: begin
                w_child_ra = ROOT;
                n_state = ST_ROOT2;
            end
            ST_ROOT2: begin
                n_node = r_child_rd;
                if (r_sym < LIT_LIMIT) begin
                    n_lit = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_mlen = 6'(r_sym - MATCH_BIAS);
                    n_phase = PH_PREFIX;
                    n_ebl = 4'd8;
                    n_acc = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_CP_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_win_we = 1'b1; w_win_wa = r_wp; w_win_wd = w_emit_byte;
                    n_wp = r_wp + 12'd1;
                    n_total = w_total_inc;
                    n_ov = 1'b1;
                    n_obyte = w_emit_byte;
                    n_ocnt = w_total_inc;
                    n_odone = (w_total_inc >= r_olen);
                    n_ostat = 1'b0;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                    if (!r_lit) begin
                        if (r_cnt + 6'd1 != r_mlen) begin
                            if (w_total_inc >= r_olen) begin
                                // match runs past the expected length
                                n_ostat = 1'b1;
                                n_phase = PH_STOPPED;
                            end else begin
                                n_olast = 1'b0;
                                n_cnt = r_cnt + 6'd1;
                                n_state = ST_CP_RD;
                            end
                        end
                    end
                end
            end
            // rebuild: gather halved leaves to the bottom
            ST_RB_A: begin
                w_child_ra = r_idx[9:0];
                w_freq_ra = r_idx[9:0];
                n_state = ST_RB_B;
            end
            ST_RB_B: begin
                if (r_child_rd >= TBL) begin
                    w_freq_we = 1'b1;  w_freq_wa = r_j;  w_freq_wd = w_half;
                    w_child_we = 1'b1; w_child_wa = r_j; w_child_wd = r_child_rd;
                    n_j = r_j + 10'd1;
                end
                if (r_idx[9:0] == ROOT) begin
                    n_j = NUM_SYM;
                    n_idx = '0;
                    n_state = ST_RB_C;
                end else begin
                    n_idx = r_idx + 12'd1;
                    n_state = ST_RB_A;
                end
            end
            // rebuild: pair nodes and insertion-sort each sum into place
            ST_RB_C: begin
                w_freq_ra = r_idx[9:0];
                n_state = ST_RB_D;
            end
            ST_RB_D: begin
                n_k = r_freq_rd;
                w_freq_ra = r_idx[9:0] + 10'd1;
                n_state = ST_RB_E;
            end
            ST_RB_E: begin
                n_k = r_k + r_freq_rd;
                n_m = r_j - 10'd1;
                w_freq_ra = r_j - 10'd1;
                w_child_ra = r_j - 10'd1;
                n_state = ST_RB_F;
            end
            ST_RB_F: begin
                if (r_k < r_freq_rd) begin
                    w_freq_we = 1'b1;  w_freq_wa = r_m + 10'd1;  w_freq_wd = r_freq_rd;
                    w_child_we = 1'b1; w_child_wa = r_m + 10'd1; w_child_wd = r_child_rd;
                    if (r_m == '0) begin
                        n_state = ST_RB_G;
                    end else begin
                        n_m = r_m - 10'd1;
                        w_freq_ra = r_m - 10'd1;
                        w_child_ra = r_m - 10'd1;
                    end
                end else begin
                    n_m = r_m + 10'd1;
                    n_state = ST_RB_G;
                end
            end
            ST_RB_G: begin
                w_freq_we = 1'b1;  w_freq_wa = r_m;  w_freq_wd = r_k;
                w_child_we = 1'b1; w_child_wa = r_m; w_child_wd = r_idx[9:0];
                if (r_j == ROOT) begin
                    n_idx = '0;
                    n_state = ST_RB_H;
                end else begin
                    n_j = r_j + 10'd1;
                    n_idx = r_idx + 12'd2;
                    n_state = ST_RB_C;
                end
            end
            // rebuild: relink parents
            ST_RB_H: begin
                w_child_ra = r_idx[9:0];
                n_state = ST_RB_I;
            end
            ST_RB_I: begin
                n_a = r_child_rd;
                w_parent_we = (r_child_rd < PAR_DEPTH);
                w_parent_wa = r_child_rd;
                w_parent_wd = r_idx[9:0];
                if (r_child_rd < TBL) begin
                    n_state = ST_RB_J;
                end else if (r_idx[9:0] == ROOT) begin
                    n_c = w_sym_node;
                    n_first = 1'b1;
                    n_state = ST_PAR;
                end else begin
                    n_idx = r_idx + 12'd1;
                    n_state = ST_RB_H;
                end
            end
            ST_RB_J: begin
                w_parent_we = 1'b1; w_parent_wa = r_a + 10'd1; w_parent_wd = r_idx[9:0];
                if (r_idx[9:0] == ROOT) begin
                    n_c = w_sym_node;
                    n_first = 1'b1;
                    n_state = ST_PAR;
                end else begin
                    n_idx = r_idx + 12'd1;
                    n_state = ST_RB_H;
                end
            end
            default: n_state = ST_INIT_LEAF;
        endcase
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_freq_we) r_freq_mem[w_freq_wa] <= w_freq_wd;
        r_freq_rd <= r_freq_mem[w_freq_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_child_we) r_child_mem[w_child_wa] <= w_child_wd;
        r_child_rd <= r_child_mem[w_child_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_parent_we) r_parent_mem[w_parent_wa] <= w_parent_wd;
        r_parent_rd <= r_parent_mem[w_parent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_win_we) r_win_mem[w_win_wa] <= w_win_wd;
        r_win_rd <= r_win_mem[w_win_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT_LEAF;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_olen  <= '0;
            r_phase <= PH_SYMBOL;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            r_phase <= n_phase;
            r_total <= n_total;
            if (i_cfg_valid) begin
                r_olen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_m     <= n_m;
        r_c     <= n_c;
        r_l     <= n_l;
        r_k     <= n_k;
        r_fl    <= n_fl;
        r_a     <= n_a;
        r_b     <= n_b;
        r_sym   <= n_sym;
        r_bit   <= n_bit;
        r_first <= n_first;
        r_lit   <= n_lit;
        r_node  <= n_node;
        r_ebl   <= n_ebl;
        r_acc   <= n_acc;
        r_mlen  <= n_mlen;
        r_wp    <= n_wp;
        r_from  <= n_from;
        r_cnt   <= n_cnt;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_odone <= n_odone;
        r_ostat <= n_ostat;
        r_ocnt  <= n_ocnt;
    end

endmodule
